/* design/clni_pkg.sv */
// shared types, constants and helper functions for the character lcd nibble interface
package clni_pkg;

    // register file and bus widths
    localparam int CFG_W             = 16;
    localparam int NUM_REGS          = 7;
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;
    localparam int COUNTER_WIDTH_DEF = 16;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_INSTR = 2'd2;
    localparam logic [1:0] CMD_CHAR  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_POWER_ON     = 3'd0;
    localparam logic [2:0] REG_FIRST_RETRY  = 3'd1;
    localparam logic [2:0] REG_SECOND_RETRY = 3'd2;
    localparam logic [2:0] REG_EN_HIGH      = 3'd3;
    localparam logic [2:0] REG_EN_LOW       = 3'd4;
    localparam logic [2:0] REG_SHORT_SETTLE = 3'd5;
    localparam logic [2:0] REG_LONG_SETTLE  = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0] RST_POWER_ON     = 16'd50000;
    localparam logic [CFG_W-1:0] RST_FIRST_RETRY  = 16'd5000;
    localparam logic [CFG_W-1:0] RST_SECOND_RETRY = 16'd200;
    localparam logic [CFG_W-1:0] RST_EN_HIGH      = 16'd50;
    localparam logic [CFG_W-1:0] RST_EN_LOW       = 16'd50;
    localparam logic [CFG_W-1:0] RST_SHORT_SETTLE = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG_SETTLE  = 16'd2000;

    // init sequence bytes
    localparam logic [7:0] INIT_WAKE     = 8'h30;
    localparam logic [7:0] INIT_4BIT     = 8'h20;
    localparam logic [7:0] INIT_FUNC_SET = 8'h28;
    localparam logic [7:0] INIT_DISP_OFF = 8'h08;
    localparam logic [7:0] INIT_CLEAR    = 8'h01;
    localparam logic [7:0] INIT_ENTRY    = 8'h06;
    localparam logic [7:0] INIT_DISP_ON  = 8'h0F;

    // instructions below this code need the long settle
    localparam logic [7:0] LONG_LIMIT = 8'h04;

    typedef struct packed {
        logic [CFG_W-1:0] power_on_wait;
        logic [CFG_W-1:0] first_retry_wait;
        logic [CFG_W-1:0] second_retry_wait;
        logic [CFG_W-1:0] enable_high_time;
        logic [CFG_W-1:0] enable_low_time;
        logic [CFG_W-1:0] short_settle;
        logic [CFG_W-1:0] long_settle;
    } t_cfg;

    // classified request as it travels through the queue
    typedef struct packed {
        logic       is_tick;
        logic       is_start;
        logic       sel;
        logic       long_settle;
        logic [7:0] payload;
    } t_req;

    // result item, packed so that the nibble lands in the lowest bits
    typedef struct packed {
        logic       accepted;
        logic       busy;
        logic       read_write;
        logic       enable_line;
        logic       reg_select;
        logic [3:0] data_nibble;
    } t_result;

    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        case (step)
            4'd4:    b = INIT_4BIT;
            4'd5:    b = INIT_FUNC_SET;
            4'd6:    b = INIT_DISP_OFF;
            4'd7:    b = INIT_CLEAR;
            4'd8:    b = INIT_ENTRY;
            4'd9:    b = INIT_DISP_ON;
            default: b = INIT_WAKE;
        endcase
        return b;
    endfunction

    function automatic logic is_long(input logic sel, input logic [7:0] b);
        return !sel && (b < LONG_LIMIT);
    endfunction

endpackage

/* design/clni_fifo.sv */
// short request queue between the front and the back
module clni_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  clni_pkg::t_req i_data,
    input  logic          i_pop,
    output clni_pkg::t_req o_data,
    output logic          o_full,
    output logic          o_empty
);
    import clni_pkg::*;

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* design/clni_front.sv */
// input side: takes stream transactions and classifies them into queue requests
module clni_front (
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [clni_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] payload
    input  logic [clni_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,  // [1:0] command
    input  logic                             i_full,
    output logic                             o_push,
    output clni_pkg::t_req                   o_req
);
    import clni_pkg::*;

    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full;

    always_comb begin
        o_req.is_tick     = (i_s_axis_tuser == CMD_TICK);
        o_req.is_start    = (i_s_axis_tuser == CMD_START);
        o_req.sel         = (i_s_axis_tuser == CMD_CHAR);
        o_req.payload     = i_s_axis_tdata;
        // settle class is known as soon as the byte is seen
        o_req.long_settle = is_long(o_req.sel, i_s_axis_tdata);
    end

endmodule

/* design/clni_back.sv */
// execution side: lcd sequencer, wait counter and output register
module clni_back #(
    parameter int COUNTER_WIDTH = clni_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  clni_pkg::t_req                    i_req,
    output logic                              o_pop,
    input  clni_pkg::t_cfg                    i_cfg,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [clni_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import clni_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POWER   = 3'd1;
    localparam logic [2:0] PH_EN_HIGH = 3'd2;
    localparam logic [2:0] PH_EN_LOW  = 3'd3;
    localparam logic [2:0] PH_SETTLE  = 3'd4;

    localparam logic [3:0]  INIT_LAST        = 4'd9;
    localparam logic [3:0]  INIT_SINGLE_LAST = 4'd4;
    localparam logic [31:0] CNT_MAX          = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

    logic [2:0]               r_phase,     n_phase;
    logic [COUNTER_WIDTH-1:0] r_wait,      n_wait;
    logic [7:0]               r_held_byte, n_held_byte;
    logic                     r_held_sel,  n_held_sel;
    logic                     r_held_long, n_held_long;
    logic                     r_low_next,  n_low_next;
    logic [3:0]               r_init_step, n_init_step;
    logic [3:0]               r_pin,       n_pin;
    logic                     r_en,        n_en;
    logic                     r_out_valid;
    t_result                  r_out_data;

    logic        busy;
    logic        n_accepted;
    logic        n_load;
    logic [CFG_W-1:0] n_load_val;
    logic [31:0] load32;
    logic [3:0]  step_inc;
    logic [CFG_W-1:0] settle_val;
    logic        do_begin;
    logic [7:0]  begin_byte;
    logic        begin_sel;
    logic        begin_single;
    logic        begin_long;
    t_result     result;

    assign o_pop           = i_req_valid && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    assign busy     = (r_phase != PH_IDLE);
    assign step_inc = r_init_step + 4'd1;

    always_comb begin
        if (r_init_step == 4'd1) begin
            settle_val = i_cfg.first_retry_wait;
        end else if (r_init_step == 4'd2) begin
            settle_val = i_cfg.second_retry_wait;
        end else if (r_init_step == 4'd3 || r_init_step == 4'd4) begin
            settle_val = i_cfg.short_settle;
        end else if (r_held_long) begin
            settle_val = i_cfg.long_settle;
        end else begin
            settle_val = i_cfg.short_settle;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_wait       = r_wait;
        n_held_byte  = r_held_byte;
        n_held_sel   = r_held_sel;
        n_held_long  = r_held_long;
        n_low_next   = r_low_next;
        n_init_step  = r_init_step;
        n_pin        = r_pin;
        n_en         = r_en;
        n_accepted   = 1'b0;
        n_load       = 1'b0;
        n_load_val   = '0;
        do_begin     = 1'b0;
        begin_byte   = i_req.payload;
        begin_sel    = i_req.sel;
        begin_single = 1'b0;
        begin_long   = i_req.long_settle;
        load32       = '0;

        if (i_req.is_tick) begin
            if (busy) begin
                if (r_wait > COUNTER_WIDTH'(1)) begin
                    n_wait = r_wait - COUNTER_WIDTH'(1);
                end else begin
                    unique case (r_phase)
                        PH_POWER: begin
                            n_init_step  = 4'd1;
                            do_begin     = 1'b1;
                            begin_byte   = init_byte(4'd1);
                            begin_sel    = 1'b0;
                            begin_single = 1'b1;
                            begin_long   = is_long(1'b0, init_byte(4'd1));
                        end
                        PH_EN_HIGH: begin
                            n_en       = 1'b0;
                            n_phase    = PH_EN_LOW;
                            n_load     = 1'b1;
                            n_load_val = i_cfg.enable_low_time;
                        end
                        PH_EN_LOW: begin
                            if (r_low_next) begin
                                n_low_next = 1'b0;
                                n_pin      = r_held_byte[3:0];
                                n_en       = 1'b1;
                                n_phase    = PH_EN_HIGH;
                                n_load     = 1'b1;
                                n_load_val = i_cfg.enable_high_time;
                            end else begin
                                n_phase    = PH_SETTLE;
                                n_load     = 1'b1;
                                n_load_val = settle_val;
                            end
                        end
                        PH_SETTLE: begin
                            if (r_init_step >= 4'd1 && r_init_step < INIT_LAST) begin
                                n_init_step  = step_inc;
                                do_begin     = 1'b1;
                                begin_byte   = init_byte(step_inc);
                                begin_sel    = 1'b0;
                                begin_single = (step_inc <= INIT_SINGLE_LAST);
                                begin_long   = is_long(1'b0, init_byte(step_inc));
                            end else begin
                                n_init_step = '0;
                                n_phase     = PH_IDLE;
                                n_wait      = '0;
                            end
                        end
                        default: begin
                            n_phase     = PH_IDLE;
                            n_en        = 1'b0;
                            n_init_step = '0;
                            n_wait      = '0;
                        end
                    endcase
                end
            end
        end else if (!busy) begin
            n_accepted = 1'b1;
            if (i_req.is_start) begin
                n_held_sel  = 1'b0;
                n_en        = 1'b0;
                n_low_next  = 1'b0;
                n_init_step = '0;
                n_phase     = PH_POWER;
                n_load      = 1'b1;
                n_load_val  = i_cfg.power_on_wait;
            end else begin
                n_init_step = '0;
                do_begin    = 1'b1;
            end
        end

        // common start of a byte: high nibble with enable raised
        if (do_begin) begin
            n_held_byte = begin_byte;
            n_held_sel  = begin_sel;
            n_held_long = begin_long;
            n_pin       = begin_byte[7:4];
            n_en        = 1'b1;
            n_low_next  = !begin_single;
            n_phase     = PH_EN_HIGH;
            n_load      = 1'b1;
            n_load_val  = i_cfg.enable_high_time;
        end

        // saturate the loaded wait to the counter range
        if (n_load) begin
            load32 = 32'(n_load_val);
            n_wait = (load32 > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH-1:0]
                                        : load32[COUNTER_WIDTH-1:0];
        end

        result.accepted    = n_accepted;
        result.busy        = (n_phase != PH_IDLE);
        result.read_write  = 1'b0;
        result.enable_line = n_en;
        result.reg_select  = n_held_sel;
        result.data_nibble = n_pin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wait      <= '0;
            r_held_byte <= '0;
            r_held_sel  <= 1'b0;
            r_held_long <= 1'b0;
            r_low_next  <= 1'b0;
            r_init_step <= '0;
            r_pin       <= '0;
            r_en        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_held_byte <= n_held_byte;
            r_held_sel  <= n_held_sel;
            r_held_long <= n_held_long;
            r_low_next  <= n_low_next;
            r_init_step <= n_init_step;
            r_pin       <= n_pin;
            r_en        <= n_en;
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= result;
        end
    end

endmodule

/* design/char_lcd_nibble_interface.sv */
// top level of the character lcd 4-bit bus driver
//
// drives a character lcd over a 4-bit data bus. time only moves on tick
// transactions (tuser command 0, one microsecond each); start (1) runs the
// power-up sequence, instruction (2) and character (3) send the tdata byte
// as high then low nibble with an enable pulse each, followed by a settle
// time (long for instructions below 0x04). start and send requests that
// arrive while busy are refused and reported with accepted = 0. every input
// transaction produces exactly one result transaction showing the lcd pins
// after that item. throughput is one transaction per clock while the result
// stream is not stalled: the front classifies and pushes into a 4-entry
// queue, the back sequencer handles one queued item per cycle with a single
// decrement-and-compare of the wait counter, and the queue lets input flow
// continue while a result waits, until the queue fills. an input passes
// through the queue and then the back's output register to the result.
// wait registers are written over apb at byte address 4*index; waits longer
// than the wait counter saturate, and a wait of zero lasts one tick.
module char_lcd_nibble_interface #(
    parameter int COUNTER_WIDTH = clni_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [clni_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] payload
    input  logic [clni_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,  // [1:0] command
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [3:0] data_nibble, [4] reg_select, [5] enable_line, [6] read_write,
    // [7] busy_res, [8] accepted, [15:9] zero
    output logic [clni_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clni_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clni_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clni_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import clni_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic       push;
    t_req       front_req;
    t_req       queue_req;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;

    // register file, writes complete in the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_on_wait     <= RST_POWER_ON;
            r_cfg.first_retry_wait  <= RST_FIRST_RETRY;
            r_cfg.second_retry_wait <= RST_SECOND_RETRY;
            r_cfg.enable_high_time  <= RST_EN_HIGH;
            r_cfg.enable_low_time   <= RST_EN_LOW;
            r_cfg.short_settle      <= RST_SHORT_SETTLE;
            r_cfg.long_settle       <= RST_LONG_SETTLE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POWER_ON:     r_cfg.power_on_wait     <= pwdata[CFG_W-1:0];
                REG_FIRST_RETRY:  r_cfg.first_retry_wait  <= pwdata[CFG_W-1:0];
                REG_SECOND_RETRY: r_cfg.second_retry_wait <= pwdata[CFG_W-1:0];
                REG_EN_HIGH:      r_cfg.enable_high_time  <= pwdata[CFG_W-1:0];
                REG_EN_LOW:       r_cfg.enable_low_time   <= pwdata[CFG_W-1:0];
                REG_SHORT_SETTLE: r_cfg.short_settle      <= pwdata[CFG_W-1:0];
                REG_LONG_SETTLE:  r_cfg.long_settle       <= pwdata[CFG_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POWER_ON:     prdata = APB_DATA_W'(r_cfg.power_on_wait);
            REG_FIRST_RETRY:  prdata = APB_DATA_W'(r_cfg.first_retry_wait);
            REG_SECOND_RETRY: prdata = APB_DATA_W'(r_cfg.second_retry_wait);
            REG_EN_HIGH:      prdata = APB_DATA_W'(r_cfg.enable_high_time);
            REG_EN_LOW:       prdata = APB_DATA_W'(r_cfg.enable_low_time);
            REG_SHORT_SETTLE: prdata = APB_DATA_W'(r_cfg.short_settle);
            REG_LONG_SETTLE:  prdata = APB_DATA_W'(r_cfg.long_settle);
            default:          prdata = '0;
        endcase
    end

    // front: accept and classify
    clni_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_full          (queue_full),
        .o_push          (push),
        .o_req           (front_req)
    );

    // decoupling queue
    clni_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_req),
        .i_pop   (pop),
        .o_data  (queue_req),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // back: sequencer and result register
    clni_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (!queue_empty),
        .i_req           (queue_req),
        .o_pop           (pop),
        .i_cfg           (r_cfg),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

/* design/clni_checker.sv */
// port-level checker for the lcd nibble interface and its bind
module clni_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [clni_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a stalled result must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // read/write line never leaves write
    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[6])
        else $error("read_write driven high");

    // a taken request always leaves the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[8] |-> o_m_axis_tdata[7])
        else $error("accepted request without busy");

    // enable strobe only rises while a sequence runs
    a_idle_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[7] |-> !o_m_axis_tdata[5])
        else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);

/* verif/char_lcd_nibble_interface_test.sv */
// self-checking stream testbench for the character lcd 4-bit bus driver
module char_lcd_nibble_interface_test;
    timeunit 1ns;
    timeprecision 1ps;

    import clni_pkg::*;

    // ------------------------------------------------------------------
    // constants of the test
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD      = 4;
    localparam int HOLD_CYCLES      = 300;  // long receiver hold-off
    localparam int RANDOM_PER_PHASE = 120;  // random transactions per timing setting
    localparam int REPORT_LIMIT     = 10;
    localparam int QUIET_CYCLES     = 4;    // margin after the last expected result has drained
    localparam int MAX_TICKS        = 30;   // ticks run against the longest waits

    // register index past the end of the register file, writes must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // power-up sequence as the panel sees it, one byte per init step
    localparam int BOOT_LAST         = 9;
    localparam int BOOT_NIBBLE_STEPS = 4;   // the first four steps send one nibble only
    localparam logic [7:0] BOOT_SEQ [BOOT_LAST] = '{
        INIT_WAKE, INIT_WAKE, INIT_WAKE, INIT_4BIT,
        INIT_FUNC_SET, INIT_DISP_OFF, INIT_CLEAR, INIT_ENTRY, INIT_DISP_ON
    };

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER,
        PH_EN_HIGH,
        PH_EN_LOW,
        PH_SETTLE
    } t_lcd_phase;

    // pin states that can be read off directly
    localparam t_result PINS_RESET = '{accepted: 1'b0, busy: 1'b0, read_write: 1'b0,
                                       enable_line: 1'b0, reg_select: 1'b0,
                                       data_nibble: 4'h0};
    localparam t_result PINS_CHAR_FF = '{accepted: 1'b1, busy: 1'b1, read_write: 1'b0,
                                         enable_line: 1'b1, reg_select: 1'b1,
                                         data_nibble: 4'hF};
    localparam t_result PINS_REFUSED_FF = '{accepted: 1'b0, busy: 1'b1, read_write: 1'b0,
                                            enable_line: 1'b1, reg_select: 1'b1,
                                            data_nibble: 4'hF};
    localparam t_result PINS_AFTER_INIT = '{accepted: 1'b0, busy: 1'b0, read_write: 1'b0,
                                            enable_line: 1'b0, reg_select: 1'b0,
                                            data_nibble: 4'hF};
    localparam t_result PINS_ANY = '0;

    // one line of the directed script: command, payload, repeat count,
    // and a hand-written expectation where chk is set
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] payload;
        logic [7:0] reps;
        logic       chk;
        t_result    want;
    } t_step_row;

    // directed script, run with enable high 1, enable low 2, short settle 0,
    // long settle 2, power-on 3, retries 0 and 1
    localparam int SCRIPT_ROWS = 21;
    localparam t_step_row SCRIPT [SCRIPT_ROWS] = '{
        '{CMD_TICK,  8'h00, 8'd1,   1'b1, PINS_RESET},       // idle tick right after reset
        '{CMD_CHAR,  8'hFF, 8'd1,   1'b1, PINS_CHAR_FF},     // top character, high nibble up
        '{CMD_INSTR, 8'h00, 8'd1,   1'b1, PINS_REFUSED_FF},  // send while busy is refused
        '{CMD_START, 8'h00, 8'd1,   1'b1, PINS_REFUSED_FF},  // start while busy is refused
        '{CMD_TICK,  8'hFF, 8'd12,  1'b0, PINS_ANY},         // finish byte, then idle lines
        '{CMD_INSTR, 8'h00, 8'd1,   1'b0, PINS_ANY},         // lowest instruction, long settle
        '{CMD_TICK,  8'h55, 8'd10,  1'b0, PINS_ANY},
        '{CMD_INSTR, 8'h03, 8'd1,   1'b0, PINS_ANY},         // last code with long settle
        '{CMD_TICK,  8'hAA, 8'd10,  1'b0, PINS_ANY},
        '{CMD_INSTR, 8'h04, 8'd1,   1'b0, PINS_ANY},         // first code with short settle
        '{CMD_TICK,  8'h00, 8'd10,  1'b0, PINS_ANY},
        '{CMD_CHAR,  8'h00, 8'd1,   1'b0, PINS_ANY},         // character zero, short settle
        '{CMD_CHAR,  8'h5A, 8'd1,   1'b0, PINS_ANY},         // refused, byte still running
        '{CMD_TICK,  8'hFF, 8'd10,  1'b0, PINS_ANY},
        '{CMD_INSTR, 8'hFF, 8'd1,   1'b0, PINS_ANY},         // top instruction
        '{CMD_TICK,  8'h0F, 8'd10,  1'b0, PINS_ANY},
        '{CMD_START, 8'hAA, 8'd1,   1'b0, PINS_ANY},         // power-up sequence
        '{CMD_TICK,  8'hF0, 8'd3,   1'b0, PINS_ANY},
        '{CMD_CHAR,  8'h33, 8'd1,   1'b0, PINS_ANY},         // refused during init
        '{CMD_TICK,  8'h3C, 8'd100, 1'b0, PINS_ANY},         // runs init to its end
        '{CMD_TICK,  8'hC3, 8'd1,   1'b1, PINS_AFTER_INIT}   // display-on nibble stays
    };

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata;   // [7:0] payload
    logic [IN_TUSER_W-1:0] i_s_axis_tuser;   // [1:0] command
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [3:0] data_nibble, [4] reg_select, [5] enable_line, [6] read_write,
    // [7] busy_res, [8] accepted, [15:9] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    char_lcd_nibble_interface DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // testbench state
    // ------------------------------------------------------------------
    int         err_count;
    int         tx_idle_pct;
    int         rx_idle_pct;
    bit         hold_req;
    bit         rx_hold;

    // expectation attached to the transaction currently offered
    bit         tag_chk;
    t_result    tag_want;

    // pin states still to come out of the result stream, oldest first
    t_result    pin_expect_q [$];

    // shadow of the timing registers
    logic [CFG_W-1:0] timing_regs [NUM_REGS];

    // shadow of the sequencer
    t_lcd_phase lcd_phase;
    logic [15:0] lcd_wait;
    logic [7:0] lcd_byte;
    logic       lcd_sel;
    logic       lcd_low_next;
    logic [3:0] lcd_step;
    logic [3:0] lcd_nibble;
    logic       lcd_en;

    // ------------------------------------------------------------------
    // pin predictor
    // ------------------------------------------------------------------

    // put a byte on the bus: high nibble first, enable goes up
    function automatic void lcd_load_byte(input logic [7:0] b, input logic sel,
                                          input bit single);
        lcd_byte     = b;
        lcd_sel      = sel;
        lcd_nibble   = b[7:4];
        lcd_en       = 1'b1;
        lcd_low_next = !single;
        lcd_phase    = PH_EN_HIGH;
        lcd_wait     = timing_regs[REG_EN_HIGH];
    endfunction

    function automatic void lcd_boot_byte();
        lcd_load_byte(BOOT_SEQ[lcd_step - 1], 1'b0, lcd_step <= BOOT_NIBBLE_STEPS);
    endfunction

    // apply one input transaction, return the pins after it
    function automatic t_result lcd_predict(input logic [1:0] cmd, input logic [7:0] payload);
        t_result r;
        logic    acc;
        acc = 1'b0;
        if (cmd == CMD_TICK) begin
            if (lcd_phase != PH_IDLE) begin
                // a loaded wait of 0 or 1 both end on this tick
                if (lcd_wait > 1) begin
                    lcd_wait = lcd_wait - 1'b1;
                end else begin
                    case (lcd_phase)
                        PH_POWER: begin
                            lcd_step = 4'd1;
                            lcd_boot_byte();
                        end
                        PH_EN_HIGH: begin
                            lcd_en    = 1'b0;
                            lcd_phase = PH_EN_LOW;
                            lcd_wait  = timing_regs[REG_EN_LOW];
                        end
                        PH_EN_LOW: begin
                            if (lcd_low_next) begin
                                lcd_low_next = 1'b0;
                                lcd_nibble   = lcd_byte[3:0];
                                lcd_en       = 1'b1;
                                lcd_phase    = PH_EN_HIGH;
                                lcd_wait     = timing_regs[REG_EN_HIGH];
                            end else begin
                                lcd_phase = PH_SETTLE;
                                // wake-up retries have their own waits
                                if (lcd_step == 4'd1) begin
                                    lcd_wait = timing_regs[REG_FIRST_RETRY];
                                end else if (lcd_step == 4'd2) begin
                                    lcd_wait = timing_regs[REG_SECOND_RETRY];
                                end else if (lcd_step == 4'd3 || lcd_step == 4'd4) begin
                                    lcd_wait = timing_regs[REG_SHORT_SETTLE];
                                end else if (!lcd_sel && lcd_byte < LONG_LIMIT) begin
                                    lcd_wait = timing_regs[REG_LONG_SETTLE];
                                end else begin
                                    lcd_wait = timing_regs[REG_SHORT_SETTLE];
                                end
                            end
                        end
                        PH_SETTLE: begin
                            if (lcd_step >= 1 && lcd_step < BOOT_LAST) begin
                                lcd_step = lcd_step + 1'b1;
                                lcd_boot_byte();
                            end else begin
                                lcd_step  = 4'd0;
                                lcd_phase = PH_IDLE;
                                lcd_wait  = '0;
                            end
                        end
                        default: begin
                            lcd_phase = PH_IDLE;
                            lcd_en    = 1'b0;
                            lcd_step  = 4'd0;
                            lcd_wait  = '0;
                        end
                    endcase
                end
            end
        end else if (lcd_phase == PH_IDLE) begin
            // requests are only taken while idle
            acc = 1'b1;
            if (cmd == CMD_START) begin
                lcd_sel      = 1'b0;
                lcd_en       = 1'b0;
                lcd_low_next = 1'b0;
                lcd_step     = 4'd0;
                lcd_phase    = PH_POWER;
                lcd_wait     = timing_regs[REG_POWER_ON];
            end else begin
                lcd_step = 4'd0;
                lcd_load_byte(payload, cmd == CMD_CHAR, 1'b0);
            end
        end
        r.data_nibble = lcd_nibble;
        r.reg_select  = lcd_sel;
        r.enable_line = lcd_en;
        r.read_write  = 1'b0;
        r.busy        = (lcd_phase != PH_IDLE);
        r.accepted    = acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, receiver and limits
    // ------------------------------------------------------------------
    always #HALF_PERIOD i_clk = ~i_clk;

    // receiver side: random stalls, or a solid hold-off while rx_hold is up
    always @(negedge i_clk) begin
        i_m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted in its own process, while the sender
    // keeps offering so the queue fills and input backpressure shows up
    initial begin
        rx_hold = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // hard limit on the whole run
    initial begin
        #1_000_000;
        $display("FAIL char_lcd_nibble_interface");
        $finish;
    end

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------

    // every accepted input transaction queues the pins it should produce
    always @(posedge i_clk) begin : input_monitor
        t_result p;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            p = lcd_predict(i_s_axis_tuser, i_s_axis_tdata);
            pin_expect_q.push_back(tag_chk ? tag_want : p);
        end
    end

    // every result transaction is matched against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[8:0]);
            if (pin_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result transaction %h", $realtime, got);
            end else begin
                want = pin_expect_q.pop_front();
                if (got.data_nibble !== want.data_nibble ||
                    got.reg_select !== want.reg_select ||
                    got.enable_line !== want.enable_line ||
                    got.read_write !== want.read_write ||
                    got.busy !== want.busy ||
                    got.accepted !== want.accepted) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT) begin
                        $display("%0t: pins mismatch, expected d=%h rs=%b e=%b rw=%b %s",
                                 $realtime, want.data_nibble, want.reg_select,
                                 want.enable_line, want.read_write, "");
                        $display("    expected busy=%b acc=%b, got d=%h rs=%b e=%b rw=%b",
                                 want.busy, want.accepted, got.data_nibble,
                                 got.reg_select, got.enable_line, got.read_write);
                        $display("    got busy=%b acc=%b", got.busy, got.accepted);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one input transaction, called right after a falling edge;
    // returns at the rising edge where it was taken
    task automatic offer(input logic [1:0] cmd, input logic [7:0] payload,
                         input bit chk, input t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        tag_chk          = chk;
        tag_want         = want;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= payload;
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // stop offering and let every expected result drain out
    task automatic wait_quiet();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-CFG_W){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < NUM_REGS)
            timing_regs[idx] = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read back all timing registers and compare with the shadow copy
    task automatic verify_regs();
        for (int k = REG_POWER_ON; k <= REG_LONG_SETTLE; k++) begin
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {k[2:0], 2'b00};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== {{(APB_DATA_W-CFG_W){1'b0}}, timing_regs[k]}) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: register %0d readback, expected %h, got %h",
                             $realtime, k, timing_regs[k], prdata);
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] pw, input logic [CFG_W-1:0] r1,
                               input logic [CFG_W-1:0] r2, input logic [CFG_W-1:0] eh,
                               input logic [CFG_W-1:0] el, input logic [CFG_W-1:0] ss,
                               input logic [CFG_W-1:0] ls);
        apb_write(REG_POWER_ON, pw);
        apb_write(REG_FIRST_RETRY, r1);
        apb_write(REG_SECOND_RETRY, r2);
        apb_write(REG_EN_HIGH, eh);
        apb_write(REG_EN_LOW, el);
        apb_write(REG_SHORT_SETTLE, ss);
        apb_write(REG_LONG_SETTLE, ls);
        verify_regs();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [1:0] cmd;
        logic [7:0] pay;
        int         dice;

        // known levels on every input from time zero
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_TICK;
        i_m_axis_tready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        err_count       = 0;
        hold_req        = 1'b0;
        tag_chk         = 1'b0;
        tag_want        = PINS_ANY;
        tx_idle_pct     = 31;
        rx_idle_pct     = 60;

        timing_regs[REG_POWER_ON]     = RST_POWER_ON;
        timing_regs[REG_FIRST_RETRY]  = RST_FIRST_RETRY;
        timing_regs[REG_SECOND_RETRY] = RST_SECOND_RETRY;
        timing_regs[REG_EN_HIGH]      = RST_EN_HIGH;
        timing_regs[REG_EN_LOW]       = RST_EN_LOW;
        timing_regs[REG_SHORT_SETTLE] = RST_SHORT_SETTLE;
        timing_regs[REG_LONG_SETTLE]  = RST_LONG_SETTLE;

        lcd_phase    = PH_IDLE;
        lcd_wait     = '0;
        lcd_byte     = '0;
        lcd_sel      = 1'b0;
        lcd_low_next = 1'b0;
        lcd_step     = '0;
        lcd_nibble   = '0;
        lcd_en       = 1'b0;

        // single reset at the start of the run
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then a write past the register file that must not land
        verify_regs();
        apb_write(REG_UNUSED, 16'hFFFF);
        verify_regs();

        // directed script with short waits
        load_timing(16'd3, 16'd0, 16'd1, 16'd1, 16'd2, 16'd0, 16'd2);
        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            repeat (SCRIPT[r].reps) begin
                @(negedge i_clk);
                offer(SCRIPT[r].cmd, SCRIPT[r].payload, SCRIPT[r].chk, SCRIPT[r].want);
            end
        end

        // random traffic: three stall patterns, four timing settings each
        for (int m = 0; m < 3; m++) begin
            for (int s = 0; s < 4; s++) begin
                wait_quiet();
                tx_idle_pct = (m == 0) ? 31 : (m == 1) ? 60 : 0;
                rx_idle_pct = (m == 0) ? 60 : (m == 1) ? 31 : 0;
                // one setting with every wait at zero and both enable times at one
                if (s == 1)
                    load_timing(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0);
                else
                    load_timing(16'($urandom_range(20)), 16'($urandom_range(10)),
                                16'($urandom_range(10)), 16'($urandom_range(4, 1)),
                                16'($urandom_range(4, 1)), 16'($urandom_range(6)),
                                16'($urandom_range(12)));
                if (m == 0 && s == 0)
                    hold_req = 1'b1;
                repeat (RANDOM_PER_PHASE) begin
                    @(negedge i_clk);
                    dice = $urandom_range(99);
                    // mostly well-formed: requests while idle, ticks while busy,
                    // with a few requests thrown at a busy block
                    if (lcd_phase == PH_IDLE ? dice < 60 : dice < 10) begin
                        dice = $urandom_range(99);
                        cmd  = (dice < 20) ? CMD_START : (dice < 60) ? CMD_INSTR : CMD_CHAR;
                        // bias instructions toward clear and home
                        if (cmd == CMD_INSTR && $urandom_range(99) < 30)
                            pay = 8'($urandom_range(3));
                        else
                            pay = 8'($urandom_range(255));
                    end else begin
                        cmd = CMD_TICK;
                        pay = 8'($urandom_range(255));
                    end
                    offer(cmd, pay, 1'b0, PINS_ANY);
                end
            end
        end

        // top of the range: every wait at its maximum, the counter runs down
        // from the longest power-on wait and requests keep being refused
        wait_quiet();
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        @(negedge i_clk);
        offer(CMD_START, 8'h00, 1'b0, PINS_ANY);
        repeat (MAX_TICKS) begin
            @(negedge i_clk);
            offer(CMD_TICK, 8'($urandom_range(255)), 1'b0, PINS_ANY);
        end
        @(negedge i_clk);
        offer(CMD_CHAR, 8'hA5, 1'b0, PINS_ANY);

        wait_quiet();
        if (err_count == 0 && pin_expect_q.size() == 0)
            $display("PASS char_lcd_nibble_interface");
        else
            $display("FAIL char_lcd_nibble_interface");
        $finish;
    end

endmodule

/* files.f */
design/clni_pkg.sv
design/clni_fifo.sv
design/clni_front.sv
design/clni_back.sv
design/char_lcd_nibble_interface.sv
design/clni_checker.sv
verif/char_lcd_nibble_interface_test.sv
